// ===== hw/rtl/ffra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types, codes and defaults of the first-fit region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int REGION_SLOTS_DEF    = 32;
  localparam int FREE_LIST_DEPTH_DEF = 32;
  localparam int ADDR_BITS_DEF       = 22;

  localparam int FIELD_W = 22;
  localparam int ID_W    = 5;
  localparam int ACT_W   = 2;
  localparam int ST_W    = 3;

  localparam int IN_W  = 56;
  localparam int OUT_W = 32;

  localparam logic [FIELD_W-1:0] HEAP_LIMIT_RST = {FIELD_W{1'b1}};

  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_ALLOC = 2'd0;
  localparam action_t ACT_FREE  = 2'd1;
  localparam action_t ACT_XLATE = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD     = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SRCH,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ffra_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ctrl
// request sequencer: slot lookup, free-list search, split, shift and growth
// ----------------------------------------------------------------------------
module ffra_ctrl import ffra_pkg::*; #(
  parameter int REGION_SLOTS    = REGION_SLOTS_DEF,
  parameter int FREE_LIST_DEPTH = FREE_LIST_DEPTH_DEF,
  parameter int ADDR_BITS       = ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [IN_W-1:0]                   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [OUT_W-1:0]                  out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [FIELD_W-1:0]                cfg_wr_data,
  output logic                                   slot_re,
  output logic      [$clog2(REGION_SLOTS)-1:0]   slot_raddr,
  input  wire logic [2*ADDR_BITS-1:0]            slot_rdata,
  output logic                                   slot_we,
  output logic      [$clog2(REGION_SLOTS)-1:0]   slot_waddr,
  output logic      [2*ADDR_BITS-1:0]            slot_wdata,
  output logic                                   hole_re,
  output logic      [$clog2(FREE_LIST_DEPTH)-1:0] hole_raddr,
  input  wire logic [2*ADDR_BITS-1:0]            hole_rdata,
  output logic                                   hole_we,
  output logic      [$clog2(FREE_LIST_DEPTH)-1:0] hole_waddr,
  output logic      [2*ADDR_BITS-1:0]            hole_wdata
);

  localparam int AW  = ADDR_BITS;
  localparam int SW  = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
  localparam int SIW = $clog2(REGION_SLOTS);
  localparam int HIW = $clog2(FREE_LIST_DEPTH);
  localparam int CW  = $clog2(FREE_LIST_DEPTH + 1);
  localparam logic [SW-1:0] AMASK = SW'((64'd1 << AW) - 64'd1);

  function automatic logic [HIW-1:0] phys(input logic [HIW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] sm;
    sm = (CW+1)'(h) + (CW+1)'(k);
    if (sm >= (CW+1)'(FREE_LIST_DEPTH)) begin
      sm = sm - (CW+1)'(FREE_LIST_DEPTH);
    end
    return HIW'(sm);
  endfunction

  state_t                  state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [FIELD_W-1:0]      size_r, size_nxt;
  logic [FIELD_W-1:0]      off_r, off_nxt;
  logic [REGION_SLOTS-1:0] valid_r, valid_nxt;
  logic [HIW-1:0]          head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           bp_r, bp_nxt;
  logic [FIELD_W-1:0]      limit_r;
  logic [CW-1:0]           issue_r, issue_nxt;
  logic                    chk_v_r, chk_v_nxt;
  logic [CW-1:0]           chk_i_r, chk_i_nxt;
  logic [CW-1:0]           shw_r, shw_nxt;
  logic                    shp_r, shp_nxt;
  status_t                 res_st_r, res_st_nxt;
  logic [AW-1:0]           res_addr_r, res_addr_nxt;
  logic                    out_v_r, out_v_nxt;
  status_t                 out_st_r, out_st_nxt;
  logic [FIELD_W-1:0]      out_addr_r, out_addr_nxt;

  logic [SIW-1:0] sidx;
  logic           slot_ok;
  logic [AW-1:0]  s_st, s_en, h_s, h_e, len;
  logic [SW-1:0]  sz, h_sum, bp_sum, lim;
  logic           fits, split;
  logic [HIW-1:0] head_m1;

  assign sidx    = SIW'(id_r);
  assign slot_ok = {4'b0, id_r} < 9'(REGION_SLOTS);
  assign s_st    = slot_rdata[AW-1:0];
  assign s_en    = slot_rdata[2*AW-1:AW];
  assign h_s     = hole_rdata[AW-1:0];
  assign h_e     = hole_rdata[2*AW-1:AW];
  assign len     = s_en - s_st;
  assign sz      = SW'(size_r);
  assign h_sum   = SW'(h_s) + sz;
  assign fits    = h_sum <= SW'(h_e);
  assign split   = h_sum < SW'(h_e);
  assign bp_sum  = SW'(bp_r) + sz;
  assign lim     = (SW'(limit_r) > AMASK) ? AMASK : SW'(limit_r);
  assign head_m1 = (head_r == '0) ? HIW'(FREE_LIST_DEPTH - 1) : head_r - 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W - ST_W - FIELD_W){1'b0}}, out_addr_r, out_st_r};

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    id_nxt       = id_r;
    size_nxt     = size_r;
    off_nxt      = off_r;
    valid_nxt    = valid_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    bp_nxt       = bp_r;
    issue_nxt    = issue_r;
    chk_v_nxt    = 1'b0;
    chk_i_nxt    = chk_i_r;
    shw_nxt      = shw_r;
    shp_nxt      = 1'b0;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    out_v_nxt    = out_v_r & ~out_tready;
    out_st_nxt   = out_st_r;
    out_addr_nxt = out_addr_r;
    slot_re      = 1'b0;
    slot_raddr   = SIW'(in_tdata[6:2]);
    slot_we      = 1'b0;
    slot_waddr   = sidx;
    slot_wdata   = {AW'(h_sum), h_s};
    hole_re      = 1'b0;
    hole_raddr   = phys(head_r, issue_r);
    hole_we      = 1'b0;
    hole_waddr   = phys(head_r, chk_i_r);
    hole_wdata   = {h_e, AW'(h_sum)};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tdata[1:0];
          id_nxt    = in_tdata[6:2];
          size_nxt  = in_tdata[28:7];
          off_nxt   = in_tdata[50:29];
          slot_re   = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        res_addr_nxt = '0;
        state_nxt    = S_DONE;
        if (!slot_ok) begin
          res_st_nxt = ST_BAD;
        end else begin
          unique case (act_r)
            ACT_ALLOC: begin
              if (size_r == '0) begin
                res_st_nxt = ST_BAD;
              end else begin
                issue_nxt = '0;
                state_nxt = S_SRCH;
              end
            end
            ACT_FREE: begin
              if (!valid_r[sidx]) begin
                res_st_nxt = ST_RANGE;
              end else if (count_r >= CW'(FREE_LIST_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                hole_we         = 1'b1;
                hole_waddr      = head_m1;
                hole_wdata      = {s_en, s_st};
                head_nxt        = head_m1;
                count_nxt       = count_r + 1'b1;
                valid_nxt[sidx] = 1'b0;
                res_st_nxt      = ST_OK;
              end
            end
            ACT_XLATE: begin
              if (!valid_r[sidx] || SW'(off_r) >= SW'(len)) begin
                res_st_nxt = ST_RANGE;
              end else begin
                res_st_nxt   = ST_OK;
                res_addr_nxt = AW'(SW'(s_st) + SW'(off_r));
              end
            end
            default: begin
              res_st_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (chk_v_r && fits) begin
          slot_we         = 1'b1;
          valid_nxt[sidx] = 1'b1;
          res_st_nxt      = ST_OK;
          res_addr_nxt    = h_s;
          if (split) begin
            hole_we   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            issue_nxt = chk_i_r + 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (issue_r < count_r) begin
          hole_re   = 1'b1;
          chk_v_nxt = 1'b1;
          chk_i_nxt = issue_r;
          issue_nxt = issue_r + 1'b1;
        end else if (!chk_v_r) begin
          state_nxt = S_DONE;
          if (bp_sum > lim) begin
            res_st_nxt   = ST_NOSPACE;
            res_addr_nxt = '0;
          end else begin
            slot_we         = 1'b1;
            slot_wdata      = {AW'(bp_sum), bp_r};
            valid_nxt[sidx] = 1'b1;
            bp_nxt          = AW'(bp_sum);
            res_st_nxt      = ST_OK;
            res_addr_nxt    = bp_r;
          end
        end
      end
      S_SHIFT: begin
        if (shp_r) begin
          hole_we    = 1'b1;
          hole_waddr = phys(head_r, shw_r);
          hole_wdata = hole_rdata;
        end
        if (issue_r < count_r) begin
          hole_re   = 1'b1;
          shw_nxt   = issue_r - 1'b1;
          shp_nxt   = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end else if (!shp_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt    = 1'b1;
          out_st_nxt   = res_st_r;
          out_addr_nxt = FIELD_W'(res_addr_r);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      head_r  <= '0;
      count_r <= '0;
      bp_r    <= '0;
      limit_r <= HEAP_LIMIT_RST;
      chk_v_r <= 1'b0;
      shp_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      bp_r    <= bp_nxt;
      chk_v_r <= chk_v_nxt;
      shp_r   <= shp_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    size_r     <= size_nxt;
    off_r      <= off_nxt;
    issue_r    <= issue_nxt;
    chk_i_r    <= chk_i_nxt;
    shw_r      <= shw_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_region_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// named-region allocator with a first-fit free list and a growing break
//
// Requests enter on the in_ stream (alloc, free or translate of a slot) and
// each one returns exactly one response on the out_ stream with a status
// and an address. One request is worked on at a time.
// Free and translate go from the slot lookup straight to the response. Alloc
// walks the free list one entry per cycle through the hole ram read port, up
// to the first hole that fits (or through all of them when the break grows);
// when an exact fit closes a hole, the holes behind it are moved up one place.
// heap_limit is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, which the block leaves unchecked.
// Reset empties all slots and the free list and clears the break pointer;
// no clearing pass is needed. A stalled receiver holds the response in the
// output register; the next request is still taken and waits only for that
// register to drain before its own response is loaded.
// ----------------------------------------------------------------------------
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int REGION_SLOTS    = REGION_SLOTS_DEF,
  parameter int FREE_LIST_DEPTH = FREE_LIST_DEPTH_DEF,
  parameter int ADDR_BITS       = ADDR_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_W-1:0]    in_tdata,   // action, region_id, size, offset
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [OUT_W-1:0]   out_tdata,  // status, address
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data
);

  localparam int SIW = $clog2(REGION_SLOTS);
  localparam int HIW = $clog2(FREE_LIST_DEPTH);

  logic                   slot_re, slot_we, hole_re, hole_we;
  logic [SIW-1:0]         slot_raddr, slot_waddr;
  logic [HIW-1:0]         hole_raddr, hole_waddr;
  logic [2*ADDR_BITS-1:0] slot_rdata, slot_wdata, hole_rdata, hole_wdata;

  ffra_ram #(
    .WIDTH (2 * ADDR_BITS),
    .DEPTH (REGION_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ffra_ram #(
    .WIDTH (2 * ADDR_BITS),
    .DEPTH (FREE_LIST_DEPTH)
  ) u_hole_ram (
    .clk   (clk),
    .we    (hole_we),
    .waddr (hole_waddr),
    .wdata (hole_wdata),
    .re    (hole_re),
    .raddr (hole_raddr),
    .rdata (hole_rdata)
  );

  ffra_ctrl #(
    .REGION_SLOTS    (REGION_SLOTS),
    .FREE_LIST_DEPTH (FREE_LIST_DEPTH),
    .ADDR_BITS       (ADDR_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .slot_re     (slot_re),
    .slot_raddr  (slot_raddr),
    .slot_rdata  (slot_rdata),
    .slot_we     (slot_we),
    .slot_waddr  (slot_waddr),
    .slot_wdata  (slot_wdata),
    .hole_re     (hole_re),
    .hole_raddr  (hole_raddr),
    .hole_rdata  (hole_rdata),
    .hole_we     (hole_we),
    .hole_waddr  (hole_waddr),
    .hole_wdata  (hole_wdata)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the first-fit region allocator
//
// Drives alloc, free and translate requests with random gaps on both streams
// and predicts each response from a model of the slot table, the free list
// and the break pointer. The heap limit is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import ffra_pkg::*;

  localparam int NSLOT = 32;
  localparam int NHOLE = 32;
  localparam int WATCHDOG = 20000;

  class alloc_scoreboard;
    logic [FIELD_W-1:0] lim;
    logic [FIELD_W-1:0] s_start[NSLOT];
    logic [FIELD_W-1:0] s_end[NSLOT];
    logic [FIELD_W-1:0] h_start[NHOLE];
    logic [FIELD_W-1:0] h_end[NHOLE];
    int unsigned nholes;
    logic [FIELD_W-1:0] brk;
    status_t exp_status[$];
    logic [FIELD_W-1:0] exp_addr[$];
    int errors;
    int checked;

    function new();
      lim = HEAP_LIMIT_RST;
      for (int i = 0; i < NSLOT; i++) begin
        s_start[i] = '0;
        s_end[i] = '0;
      end
      nholes = 0;
      brk = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_request(action_t act, int rid, logic [FIELD_W-1:0] sz,
                               logic [FIELD_W-1:0] off);
      status_t st;
      logic [FIELD_W:0] a;
      logic [FIELD_W-1:0] adr;
      bit hit;
      st = ST_BAD;
      adr = '0;
      hit = 0;
      if (act == ACT_ALLOC && sz != 0) begin
        for (int i = 0; i < nholes && !hit; i++) begin
          if ({1'b0, h_start[i]} + sz <= {1'b0, h_end[i]}) begin
            hit = 1;
            adr = h_start[i];
            if ({1'b0, adr} + sz < {1'b0, h_end[i]}) begin
              h_start[i] = adr + sz;
            end else begin
              for (int j = i; j + 1 < nholes; j++) begin
                h_start[j] = h_start[j+1];
                h_end[j] = h_end[j+1];
              end
              nholes--;
            end
            s_start[rid] = adr;
            s_end[rid] = adr + sz;
            st = ST_OK;
          end
        end
        if (!hit) begin
          a = {1'b0, brk} + sz;
          if (a > {1'b0, lim}) begin
            st = ST_NOSPACE;
          end else begin
            s_start[rid] = brk;
            s_end[rid] = a[FIELD_W-1:0];
            adr = brk;
            brk = a[FIELD_W-1:0];
            st = ST_OK;
          end
        end
      end else if (act == ACT_FREE) begin
        if (s_start[rid] >= s_end[rid]) begin
          st = ST_RANGE;
        end else if (nholes >= NHOLE) begin
          st = ST_FULL;
        end else begin
          for (int j = nholes; j > 0; j--) begin
            h_start[j] = h_start[j-1];
            h_end[j] = h_end[j-1];
          end
          h_start[0] = s_start[rid];
          h_end[0] = s_end[rid];
          nholes++;
          s_start[rid] = '0;
          s_end[rid] = '0;
          st = ST_OK;
        end
      end else if (act == ACT_XLATE) begin
        if (s_start[rid] >= s_end[rid] || off >= s_end[rid] - s_start[rid]) begin
          st = ST_RANGE;
        end else begin
          st = ST_OK;
          adr = s_start[rid] + off;
        end
      end
      if (st != ST_OK) adr = '0;
      exp_status.push_back(st);
      exp_addr.push_back(adr);
    endfunction

    function void check_response(logic [OUT_W-1:0] d);
      status_t es;
      logic [FIELD_W-1:0] ea;
      if (exp_status.size() == 0) begin
        $error("response with nothing expected: %h", d);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ea = exp_addr.pop_front();
      checked++;
      if (d[ST_W-1:0] !== es) begin
        $error("status: expected %0d, actual %0d", es, d[ST_W-1:0]);
        errors++;
      end
      if (d[ST_W +: FIELD_W] !== ea) begin
        $error("address: expected %0h, actual %0h", ea, d[ST_W +: FIELD_W]);
        errors++;
      end
      if (d[OUT_W-1:ST_W+FIELD_W] !== '0) begin
        $error("pad: expected 0, actual %0h", d[OUT_W-1:ST_W+FIELD_W]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;

  alloc_scoreboard sb;
  int idle_cycles = 0;
  int n_requests = 0;
  bit stall_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  first_fit_region_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // random backpressure on responses
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = stall_on ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("watchdog expired");
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_request(action_t act, int rid, logic [FIELD_W-1:0] sz,
                              logic [FIELD_W-1:0] off, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {off, sz, rid[ID_W-1:0], act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, rid, sz, off);
    n_requests++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(logic [FIELD_W-1:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.lim = v;
  endtask

  function automatic logic [FIELD_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return FIELD_W'($urandom_range(1, 64));
    if (r < 90) return FIELD_W'($urandom_range(1, 4096));
    if (r < 97) return FIELD_W'($urandom());
    return '0;
  endfunction

  task automatic random_phase(int count);
    int r;
    int rid;
    action_t act;
    logic [FIELD_W-1:0] off;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      rid = $urandom_range(0, NSLOT - 1);
      if (r < 45) act = ACT_ALLOC;
      else if (r < 70) act = ACT_FREE;
      else if (r < 97) act = ACT_XLATE;
      else act = action_t'(3);
      if ($urandom_range(0, 3) != 0) begin
        off = (sb.s_end[rid] > sb.s_start[rid]) ?
              FIELD_W'($urandom_range(0, sb.s_end[rid] - sb.s_start[rid])) :
              FIELD_W'($urandom_range(0, 7));
      end else begin
        off = FIELD_W'($urandom());
      end
      send_request(act, rid, rand_size(), off, (k % 200) < 150);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed requests
    send_request(ACT_XLATE, 0, 0, 0, 0);
    send_request(ACT_FREE, 0, 0, 0, 0);
    send_request(ACT_ALLOC, 0, 0, 0, 0);
    send_request(action_t'(3), 1, 5, 0, 0);
    send_request(ACT_ALLOC, 0, 100, 0, 0);
    send_request(ACT_ALLOC, 31, 50, 0, 0);
    send_request(ACT_XLATE, 0, 0, 99, 0);
    send_request(ACT_XLATE, 0, 0, 100, 0);
    send_request(ACT_XLATE, 31, 0, 22'h3fffff, 0);
    send_request(ACT_FREE, 0, 0, 0, 0);
    send_request(ACT_FREE, 0, 0, 0, 0);
    send_request(ACT_ALLOC, 1, 30, 0, 0);
    send_request(ACT_ALLOC, 2, 70, 0, 0);
    send_request(ACT_ALLOC, 2, 10, 0, 0);
    send_request(ACT_ALLOC, 3, 22'h3fffff, 0, 0);
    send_request(ACT_ALLOC, 4, 22'h3fffff - 150, 0, 0);
    send_request(ACT_XLATE, 4, 0, 22'h3fffff - 151, 0);
    send_request(ACT_ALLOC, 5, 1, 0, 0);
    send_request(ACT_ALLOC, 5, 22'h2aaaaa, 0, 0);
    drain();

    // alloc and free every slot with the heap limit at 4000, then alloc four more
    write_limit(22'd4000);
    for (int i = 0; i < NSLOT; i++) send_request(ACT_ALLOC, i, 3, 0, 1);
    for (int i = 0; i < NSLOT; i++) send_request(ACT_FREE, i, 0, 0, 1);
    for (int i = 0; i < 4; i++) send_request(ACT_ALLOC, i, 1, 0, 1);
    drain();

    stall_on = 1;
    write_limit(22'd0);
    random_phase(60);
    drain();
    write_limit(22'd3000);
    random_phase(400);
    drain();
    write_limit(22'h3fffff);
    random_phase(350);
    drain();
    write_limit(FIELD_W'($urandom_range(5000, 200000)));
    random_phase(220);
    drain();

    $display("ran %0d requests, checked %0d responses, five heap limits",
             n_requests, sb.checked);
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_ram.sv
hw/rtl/ffra_ctrl.sv
hw/rtl/first_fit_region_allocator.sv
tb/sv/tb_top.sv
